// ===== hdl/assert_macros.svh =====
// Assertion macros used by the boundary detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define MBOX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define MBOX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mbox_pkg.sv =====
// Types, constants and helper functions of the mailbox boundary detector.
package mbox_pkg;

  localparam int CHUNK_BYTES_DEF = 4095;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 12;
  localparam int NUM_W           = 31;
  localparam int CFG_IDX_W       = 2;
  localparam int VAL_W           = 10;
  localparam int PREFIX_LEN      = 5;
  localparam int MIN_FROM_LEN    = 20;

  localparam logic [NUM_W-1:0]  NUM_MAX  = {NUM_W{1'b1}};
  localparam logic [VAL_W-1:0]  YEAR_MIN = VAL_W'(90);
  localparam logic [VAL_W-1:0]  VAL_CAP  = VAL_W'(1000);

  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALLOW_BARE   = 2'd0,
    REG_FIRST_NUMBER = 2'd1
  } cfg_reg_t;

  // Phases of the year read that follows a colon.
  typedef enum logic [2:0] {
    PH_D1,
    PH_D2,
    PH_WS,
    PH_SIGN,
    PH_DIG,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic             valid;
    logic             ok;
    phase_t           phase;
    logic             neg;
    logic [VAL_W-1:0] val;
  } cand_t;

  typedef struct packed {
    logic [LEN_W-1:0] chunk_length;
    logic             from_line;
    logic             starts_message;
    logic [NUM_W-1:0] message_number;
    logic             corrupt;
    logic             file_ended;
  } result_t;

  function automatic logic is_dig(input logic [BYTE_W-1:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  function automatic logic is_ws(input logic [BYTE_W-1:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

  // Expected byte of the "From " prefix at a given position.
  function automatic logic [BYTE_W-1:0] prefix_byte(input logic [2:0] idx);
    logic [BYTE_W-1:0] r;
    case (idx)
      3'd0:    r = 8'h46;
      3'd1:    r = 8'h72;
      3'd2:    r = 8'h6F;
      3'd3:    r = 8'h6D;
      3'd4:    r = CHAR_SPACE;
      default: r = CHAR_SPACE;
    endcase
    return r;
  endfunction

  function automatic logic [NUM_W-1:0] sat_inc(input logic [NUM_W-1:0] v);
    return (v == NUM_MAX) ? NUM_MAX : v + NUM_W'(1);
  endfunction

endpackage

// ===== hdl/mbox_if.sv =====
// Channel interfaces of the mailbox boundary detector.
interface mbox_in_if import mbox_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface mbox_out_if import mbox_pkg::*;;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] chunk_length;
  logic             from_line;
  logic             starts_message;
  logic [NUM_W-1:0] message_number;
  logic             corrupt;
  logic             file_ended;

  modport source (output valid, output chunk_length, output from_line,
                  output starts_message, output message_number, output corrupt,
                  output file_ended, input ready);
  modport sink   (input valid, input chunk_length, input from_line,
                  input starts_message, input message_number, input corrupt,
                  input file_ended, output ready);
endinterface

interface mbox_cfg_if import mbox_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [NUM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/mbox_message_boundary_detector.sv =====
// Mailbox boundary detector: cuts a byte stream into chunks and numbers messages.
// A chunk's result is registered: its closing byte passes the input register, then the result buffer.
// Throughput: one byte per cycle; the per-byte scan is one pass between input and result regs.
// Results queue in a three-entry output buffer, so input only stalls when the sink stalls.
// Reset (rst, synchronous): clears chunk state and the halt, allow_bare=0, counter=0.
// No clearing pass after reset; the block takes bytes in the first cycle after rst falls.
`include "assert_macros.svh"

module mbox_message_boundary_detector import mbox_pkg::*; #(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mbox_cfg_if.sink   cfg,
  mbox_in_if.sink    stream,
  mbox_out_if.source result
);

  // Position counter holds the chunk length up to the chunk limit.
  localparam int POS_W      = $clog2(CHUNK_BYTES + 1);
  localparam int FIFO_DEPTH = 3;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int NCAND      = 3;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(CHUNK_BYTES - 1);

  // ---------------------------------------------------------------- input register
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_eoi;
  logic              take_in;

  // ---------------------------------------------------------------- scan state
  logic [POS_W-1:0]  chunk_position;
  logic              prefix_matched;
  logic [3:0]        dig_hist;       // digit flags of the last four bytes, bit 0 newest
  cand_t             cand [NCAND];   // newest colon first
  logic [POS_W-1:0]  cpos [NCAND];
  logic              previous_chunk_partial;
  logic              message_bare;
  logic              at_file_start;
  logic [NUM_W-1:0]  message_counter;
  logic              halted;
  logic              allow_bare;

  // ---------------------------------------------------------------- next values
  logic              proc;
  logic              prefix_next;
  cand_t             fed [NCAND];
  cand_t             cand_next [NCAND];
  logic [POS_W-1:0]  cpos_next [NCAND];
  logic              new_colon;
  logic [POS_W-1:0]  len;
  logic              chunk_end;
  logic              found;
  logic              from;
  logic              bad;
  logic              starts;
  logic [NUM_W-1:0]  counter_inc;

  // ---------------------------------------------------------------- result buffer
  result_t           fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;
  result_t           push_entry;
  result_t           head;

  // Advance the year read of one colon candidate by one byte.
  function automatic cand_t cand_feed(input cand_t c, input logic [BYTE_W-1:0] b);
    cand_t             r;
    logic [VAL_W+3:0]  v;
    logic              take_digit;
    r          = c;
    v          = '0;
    take_digit = 1'b0;
    if (c.valid) begin
      case (c.phase)
        PH_D1, PH_D2: begin
          if (!is_dig(b)) begin
            r.ok    = 1'b0;
            r.phase = PH_DONE;
          end else begin
            r.phase = (c.phase == PH_D1) ? PH_D2 : PH_WS;
          end
        end
        PH_WS: begin
          if (is_ws(b)) begin
            r.phase = PH_WS;
          end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
            r.neg   = (b == CHAR_MINUS);
            r.phase = PH_SIGN;
          end else begin
            take_digit = 1'b1;
          end
        end
        PH_SIGN, PH_DIG: begin
          take_digit = 1'b1;
        end
        default: begin
          r.phase = c.phase;
        end
      endcase
      if (take_digit) begin
        if (is_dig(b)) begin
          // val * 10 + digit, capped well above any year threshold
          v       = {c.val, 3'b000} + {2'b00, c.val, 1'b0} + (VAL_W + 4)'(b[3:0]);
          r.val   = (v > (VAL_W + 4)'(VAL_CAP)) ? VAL_CAP : v[VAL_W-1:0];
          r.phase = PH_DIG;
        end else begin
          r.phase = PH_DONE;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- input side
  // Accept while the buffer can hold the result of the byte in flight and this one.
  assign stream.ready = ({1'b0, count} + (CNT_W + 1)'(s1_valid)) <= (CNT_W + 1)'(FIFO_DEPTH - 1);
  assign take_in      = stream.valid && stream.ready;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take_in;
    end
    if (take_in) begin
      s1_byte <= stream.data_byte;
      s1_eoi  <= stream.end_of_input;
    end
  end

  // ---------------------------------------------------------------- per-byte scan
  // Drop bytes while halted; only a reset restarts the block.
  assign proc = s1_valid && !halted;

  assign prefix_next = prefix_matched &&
                       !((chunk_position < POS_W'(PREFIX_LEN)) &&
                         (s1_byte != prefix_byte(chunk_position[2:0])));

  assign new_colon = (s1_byte == CHAR_COLON) && (chunk_position >= POS_W'(PREFIX_LEN));
  assign len       = chunk_position + POS_W'(1);
  assign chunk_end = (s1_byte == CHAR_NL) || (chunk_position == LAST_POS) || s1_eoi;

  // Feed every candidate, then push a fresh one for a colon past the prefix.
  always_comb begin
    for (int i = 0; i < NCAND; i++) begin
      fed[i] = cand_feed(cand[i], s1_byte);
    end
    if (new_colon) begin
      cand_next[2]       = fed[1];
      cand_next[1]       = fed[0];
      cpos_next[2]       = cpos[1];
      cpos_next[1]       = cpos[0];
      cand_next[0].valid = 1'b1;
      cand_next[0].ok    = dig_hist[0] && dig_hist[1] && dig_hist[3];
      cand_next[0].phase = PH_D1;
      cand_next[0].neg   = 1'b0;
      cand_next[0].val   = '0;
      cpos_next[0]       = chunk_position;
    end else begin
      for (int i = 0; i < NCAND; i++) begin
        cand_next[i] = fed[i];
        cpos_next[i] = cpos[i];
      end
    end
  end

  // The From test uses the newest colon that leaves room for two digits after it.
  always_comb begin
    found = 1'b0;
    from  = 1'b0;
    for (int i = 0; i < NCAND; i++) begin
      if (!found && cand_next[i].valid &&
          (({1'b0, cpos_next[i]} + (POS_W + 1)'(3)) <= {1'b0, len})) begin
        found = 1'b1;
        from  = cand_next[i].ok && !cand_next[i].neg && (cand_next[i].val > YEAR_MIN);
      end
    end
    if (!(prefix_next && (len >= POS_W'(MIN_FROM_LEN)))) begin
      from = 1'b0;
    end
  end

  // Message start decision for a completed chunk.
  always_comb begin
    bad    = 1'b0;
    starts = 1'b0;
    if (at_file_start) begin
      if (!from && !allow_bare) begin
        bad = 1'b1;
      end else begin
        starts = 1'b1;
      end
    end else begin
      starts = !previous_chunk_partial && !message_bare && from;
    end
  end

  assign counter_inc = sat_inc(message_counter);

  assign push = proc && chunk_end;

  always_comb begin
    push_entry.chunk_length   = LEN_W'(len);
    push_entry.from_line      = from;
    push_entry.starts_message = starts;
    push_entry.message_number = (bad || starts) ? counter_inc : message_counter;
    push_entry.corrupt        = bad;
    push_entry.file_ended     = s1_eoi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_position         <= '0;
      prefix_matched         <= 1'b1;
      dig_hist               <= '0;
      for (int i = 0; i < NCAND; i++) begin
        cand[i] <= '0;
        cpos[i] <= '0;
      end
      previous_chunk_partial <= 1'b0;
      message_bare           <= 1'b0;
      at_file_start          <= 1'b1;
      message_counter        <= '0;
      halted                 <= 1'b0;
      allow_bare             <= 1'b0;
    end else begin
      if (proc) begin
        if (chunk_end) begin
          // Clear the chunk scan and settle the message state.
          chunk_position <= '0;
          prefix_matched <= 1'b1;
          dig_hist       <= '0;
          for (int i = 0; i < NCAND; i++) begin
            cand[i] <= '0;
            cpos[i] <= '0;
          end
          if (bad) begin
            halted <= 1'b1;
          end
          if (starts) begin
            message_counter <= counter_inc;
          end
          if (s1_eoi) begin
            at_file_start          <= 1'b1;
            message_bare           <= 1'b0;
            previous_chunk_partial <= 1'b0;
          end else begin
            previous_chunk_partial <= (s1_byte != CHAR_NL);
            if (at_file_start && !bad) begin
              at_file_start <= 1'b0;
              message_bare  <= !from;
            end
          end
        end else begin
          chunk_position <= len;
          prefix_matched <= prefix_next;
          dig_hist       <= {dig_hist[2:0], is_dig(s1_byte)};
          for (int i = 0; i < NCAND; i++) begin
            cand[i] <= cand_next[i];
            cpos[i] <= cpos_next[i];
          end
        end
      end
      // The user must write registers only while idle; the block does not enforce it. A counter load wins.
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ALLOW_BARE:   allow_bare      <= cfg.data[0];
          REG_FIRST_NUMBER: message_counter <= cfg.data;
          default:          allow_bare      <= allow_bare;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- result buffer
  assign pop          = result.valid && result.ready;
  assign head         = fifo_mem[rd_ptr];
  assign result.valid = (count != '0);

  assign result.chunk_length   = head.chunk_length;
  assign result.from_line      = head.from_line;
  assign result.starts_message = head.starts_message;
  assign result.message_number = head.message_number;
  assign result.corrupt        = head.corrupt;
  assign result.file_ended     = head.file_ended;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
    if (push) begin
      fifo_mem[wr_ptr] <= push_entry;
    end
  end

  // ---------------------------------------------------------------- assertions
  `MBOX_ASSERT_NEXT(a_halt_sticky, halted, halted, "halt released without reset")
  `MBOX_ASSERT_NEXT(a_corrupt_halts, push && push_entry.corrupt, halted,
                    "corrupt chunk did not halt the block")
  `MBOX_ASSERT(a_start_needs_from,
               (push && push_entry.starts_message && !at_file_start) |-> push_entry.from_line,
               "message start inside a file without a From line")
  `MBOX_ASSERT(a_bare_mid_file, message_bare |-> !at_file_start,
               "bare message flagged at file start")
  `MBOX_ASSERT(a_no_overflow, !(push && !pop && count == CNT_W'(FIFO_DEPTH)),
               "result buffer overflow")

endmodule
